@@ hdl/kfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kalman residual filter package
// Field widths, register indexes, reset values and operation codes.
// ----------------------------------------------------------------------------
package kfr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int REG_W    = 24;
	localparam int IDX_W    = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [REG_W-1:0]    reg_t;
	typedef logic        [IDX_W-1:0]    reg_idx_t;

	localparam reg_idx_t REG_PROCESS_NOISE     = 2'd0;
	localparam reg_idx_t REG_MEASUREMENT_NOISE = 2'd1;
	localparam reg_idx_t REG_INITIAL_ERROR     = 2'd2;

	localparam reg_t RST_PROCESS_NOISE     = 24'd655;
	localparam reg_t RST_MEASUREMENT_NOISE = 24'd65536;
	localparam reg_t RST_INITIAL_ERROR     = 24'd65536;

	localparam reg_t P_MAX = 24'hFFFFFF;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

endpackage
`default_nettype wire

@@ hdl/kfr_sample_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kalman residual filter sample channel
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface kfr_sample_if;
	logic             valid;
	logic             ready;
	logic             op;
	kfr_pkg::sample_t sample;
	logic             frame_last;

	modport source (output valid, output op, output sample, output frame_last, input ready);
	modport sink   (input valid, input op, input sample, input frame_last, output ready);
endinterface
`default_nettype wire

@@ hdl/kfr_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kalman residual filter result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface kfr_result_if;
	logic             valid;
	logic             ready;
	kfr_pkg::sample_t residual;
	logic             last;

	modport source (output valid, output residual, output last, input ready);
	modport sink   (input valid, input residual, input last, output ready);
endinterface
`default_nettype wire

@@ hdl/scalar_kalman_residual_filter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scalar Kalman residual filter
// One-dimensional Kalman tracker on Q1.15 samples; emits sample minus the new
// estimate. A restoring serial divider and one shared 18x26 multiplier run
// under a small sequencer.
// A sample's result is registered after the 16-step gain division, three
// passes through the shared multiplier and the error update; a restart item
// gives no result. No new item is accepted until the last sample's result has
// moved into the output register, which waits while a result is untaken.
// Reset: registers take their reset values, error estimate = initial error,
// tracked estimate = 0, no result pending.
// ----------------------------------------------------------------------------
module scalar_kalman_residual_filter_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire kfr_pkg::reg_idx_t cfg_idx,
	input  wire kfr_pkg::reg_t     cfg_data,
	kfr_sample_if.sink             sample_ch,
	kfr_result_if.source           residual_ch
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MK   = 3'd2;
	localparam logic [2:0] S_EST  = 3'd3;
	localparam logic [2:0] S_MT1  = 3'd4;
	localparam logic [2:0] S_MT2  = 3'd5;
	localparam logic [2:0] S_SUM  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	function automatic kfr_pkg::sample_t sat16(input logic signed [17:0] v);
		if (v > 18'sd32767)
			return 16'sh7FFF;
		else if (v < -18'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	logic [2:0]        state_q;
	logic [3:0]        cnt_q;
	kfr_pkg::reg_t     q_q, r_q, init_q;
	kfr_pkg::reg_t     p_q;
	kfr_pkg::sample_t  est_q;
	kfr_pkg::sample_t  x_q;
	logic              last_q;
	logic [24:0]       den_q;
	logic [24:0]       rem_q;
	logic [15:0]       qt_q;
	logic [15:0]       k_q;
	logic signed [43:0] mul_q;
	logic [16:0]       mag_q;
	kfr_pkg::sample_t  res_q;
	logic [24:0]       t1_q;
	logic              ov_q;
	kfr_pkg::sample_t  ores_q;
	logic              olast_q;

	logic              acc;
	logic [25:0]       sh;
	logic              ge;
	logic [15:0]       kfix;
	logic signed [16:0] d;
	logic signed [17:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [43:0] rnd;
	logic signed [17:0] step18;
	logic signed [17:0] sum18;
	kfr_pkg::sample_t  newest;
	logic signed [16:0] step2;
	logic signed [17:0] resid18;
	logic [26:0]       t2;
	logic [27:0]       np;

	assign sample_ch.ready = (state_q == S_IDLE);
	assign acc = sample_ch.valid && sample_ch.ready;

	assign sh   = {rem_q, 1'b0};
	assign ge   = sh >= {1'b0, den_q};
	assign kfix = (r_q == '0) ? ((p_q != '0) ? 16'hFFFF : 16'h0000) : qt_q;
	assign d    = 17'(x_q) - 17'(est_q);

	always_comb begin
		case (state_q)
			S_MK: begin
				mul_a = signed'({2'b00, kfix});
				mul_b = 26'(d);
			end
			S_MT1: begin
				mul_a = signed'({1'b0, 17'(18'd65536 - {2'b00, k_q})});
				mul_b = signed'({2'b00, p_q});
			end
			default: begin
				mul_a = signed'({1'b0, mag_q});
				mul_b = signed'({2'b00, q_q});
			end
		endcase
	end

	assign rnd     = mul_q + 44'sd32768;
	assign step18  = rnd[33:16];
	assign sum18   = 18'(est_q) + step18;
	assign newest  = sat16(sum18);
	assign step2   = 17'(newest) - 17'(est_q);
	assign resid18 = 18'(x_q) - 18'(newest);
	assign t2      = 27'((mul_q[42:0] + 43'd16384) >> 15);
	assign np      = {3'b000, t1_q} + {1'b0, t2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= kfr_pkg::RST_PROCESS_NOISE;
			r_q    <= kfr_pkg::RST_MEASUREMENT_NOISE;
			init_q <= kfr_pkg::RST_INITIAL_ERROR;
		end else if (cfg_we) begin
			case (cfg_idx)
				kfr_pkg::REG_PROCESS_NOISE:     q_q    <= cfg_data;
				kfr_pkg::REG_MEASUREMENT_NOISE: r_q    <= cfg_data;
				kfr_pkg::REG_INITIAL_ERROR:     init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			p_q     <= kfr_pkg::RST_INITIAL_ERROR;
			est_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (sample_ch.op == kfr_pkg::OP_RESTART) begin
							p_q   <= init_q;
							est_q <= '0;
						end else begin
							state_q <= S_DIV;
							cnt_q   <= '0;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= S_MK;
				end
				S_MK:  state_q <= S_EST;
				S_EST: begin
					est_q   <= newest;
					state_q <= S_MT1;
				end
				S_MT1: state_q <= S_MT2;
				S_MT2: state_q <= S_SUM;
				S_SUM: begin
					p_q     <= (np > {4'b0000, kfr_pkg::P_MAX}) ? kfr_pkg::P_MAX : np[23:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || residual_ch.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (acc) begin
			x_q    <= sample_ch.sample;
			last_q <= sample_ch.frame_last;
			den_q  <= {1'b0, p_q} + {1'b0, r_q};
			rem_q  <= {1'b0, p_q};
		end
		if (state_q == S_DIV) begin
			rem_q <= ge ? 25'(sh - {1'b0, den_q}) : sh[24:0];
			qt_q  <= {qt_q[14:0], ge};
		end
		if (state_q == S_MK)
			k_q <= kfix;
		if (state_q == S_EST) begin
			mag_q <= step2[16] ? 17'(-step2) : 17'(step2);
			res_q <= sat16(resid18);
		end
		if (state_q == S_MT2)
			t1_q <= 25'((mul_q[42:0] + 43'd32768) >> 16);
		if (state_q == S_OUT && (!ov_q || residual_ch.ready)) begin
			ores_q  <= res_q;
			olast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (state_q == S_OUT && (!ov_q || residual_ch.ready))
			ov_q <= 1'b1;
		else if (residual_ch.ready)
			ov_q <= 1'b0;
	end

	assign residual_ch.valid    = ov_q;
	assign residual_ch.residual = ores_q;
	assign residual_ch.last     = olast_q;

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == 4'd15) |=> (state_q == S_MK))
		else $error("gain division did not end after sixteen steps");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && sample_ch.op == kfr_pkg::OP_SAMPLE) |-> ##22 (state_q == S_OUT))
		else $error("sample item did not reach output stage in time");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && sample_ch.op == kfr_pkg::OP_RESTART) |=>
		(p_q == $past(init_q) && est_q == '0 && state_q == S_IDLE))
		else $error("restart item did not reload filter state");

	a_est_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EST && !acc) |=> $stable(est_q))
		else $error("tracked estimate changed outside its update step");

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman residual filter testbench
// Sends samples and restarts through the input channel with random idling on
// both sides and one long output stall. A bit-exact fixed-point tracker
// predicts every residual, and each result is checked in order, field by
// field, across several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

	localparam int                CLK_HALF     = 10;
	localparam int                CYCLE_LIMIT  = 500000;
	localparam int                DRAIN_TAIL   = 30;
	localparam int                RANDOM_ITEMS = 1300;
	localparam int                LONG_STALL   = 600;
	localparam kfr_pkg::reg_idx_t REG_SPARE    = 2'd3;
	localparam kfr_pkg::sample_t  SAMPLE_MAX   = 16'sh7FFF;
	localparam kfr_pkg::sample_t  SAMPLE_MIN   = 16'sh8000;

	typedef struct packed {
		kfr_pkg::sample_t residual;
		logic             last;
	} residual_item_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	kfr_pkg::reg_idx_t cfg_idx;
	kfr_pkg::reg_t     cfg_data;

	kfr_sample_if sample_ch ();
	kfr_result_if residual_ch ();

	scalar_kalman_residual_filter_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.sample_ch   (sample_ch),
		.residual_ch (residual_ch)
	);

	kfr_pkg::reg_t    noise_q;
	kfr_pkg::reg_t    noise_r;
	kfr_pkg::reg_t    err_init;
	kfr_pkg::reg_t    err_p;
	kfr_pkg::sample_t track_est;
	residual_item_t   pending_residuals[$];

	bit tx_steady;
	bit rx_steady;
	int rx_stall;
	int cycle_count;
	int mismatches;
	int items_sent;
	int restarts_sent;
	int residuals_checked;
	int settings_loaded;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("scalar_kalman_residual_filter_top test failed");
		$finish;
	end

	function automatic kfr_pkg::sample_t sat16(input longint v);
		if (v > 32767) return SAMPLE_MAX;
		if (v < -32768) return SAMPLE_MIN;
		return kfr_pkg::sample_t'(v);
	endfunction

	// gain Q0.16, estimate step Q1.15, error Q8.16
	function automatic residual_item_t kalman_update(input kfr_pkg::sample_t x, input logic fl);
		logic [63:0]    den;
		logic [63:0]    gain;
		logic [63:0]    mag;
		logic [63:0]    t1;
		logic [63:0]    t2;
		logic [63:0]    np;
		longint         prod;
		longint         step;
		longint         nxt;
		residual_item_t r;
		den = 64'(err_p) + 64'(noise_r);
		if (den == 0) begin
			gain = '0;
		end else begin
			gain = (64'(err_p) << 16) / den;
			if (gain > 64'd65535) gain = 64'd65535;
		end
		prod = longint'(gain) * (longint'(x) - longint'(track_est));
		step = (prod + 64'sd32768) >>> 16;
		nxt = sat16(longint'(track_est) + step);
		step = nxt - longint'(track_est);
		r.residual = sat16(longint'(x) - nxt);
		r.last = fl;
		mag = (step < 0) ? -step : step;
		t1 = ((64'd65536 - gain) * err_p + 64'd32768) >> 16;
		t2 = (mag * noise_q + 64'd16384) >> 15;
		np = t1 + t2;
		if (np > kfr_pkg::P_MAX) np = kfr_pkg::P_MAX;
		err_p = kfr_pkg::reg_t'(np);
		track_est = kfr_pkg::sample_t'(nxt);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_residuals
		residual_item_t want;
		if (residual_ch.valid === 1'b1 && residual_ch.ready === 1'b1) begin
			if (pending_residuals.size() == 0) begin
				report_mismatch($sformatf("unexpected residual %0d", residual_ch.residual));
			end else begin
				want = pending_residuals.pop_front();
				residuals_checked++;
				if (residual_ch.residual !== want.residual) begin
					report_mismatch($sformatf("residual %0d, expected %0d",
						residual_ch.residual, want.residual));
				end
				if (residual_ch.last !== want.last) begin
					report_mismatch($sformatf("last %b, expected %b",
						residual_ch.last, want.last));
				end
			end
		end
	end

	// long stall while rx_stall runs, else a random wait after each item taken (none when steady)
	initial begin : drive_ready
		int rx_wait;
		rx_wait = 0;
		residual_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_stall > 0) begin
				rx_stall--;
				residual_ch.ready <= 1'b0;
			end else if (residual_ch.valid === 1'b1 && residual_ch.ready === 1'b1) begin
				rx_wait = rx_steady ? 0 : $urandom_range(0, 13);
				residual_ch.ready <= (rx_wait == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
				residual_ch.ready <= (rx_wait == 0);
			end else begin
				residual_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic op, input kfr_pkg::sample_t s, input logic fl);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.op         <= op;
		sample_ch.sample     <= s;
		sample_ch.frame_last <= fl;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		items_sent++;
		if (op == kfr_pkg::OP_RESTART) begin
			restarts_sent++;
			err_p = err_init;
			track_est = '0;
		end else begin
			pending_residuals.push_back(kalman_update(s, fl));
		end
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_residuals.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic load_regs(input kfr_pkg::reg_t q, input kfr_pkg::reg_t r,
		input kfr_pkg::reg_t p0);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= kfr_pkg::REG_PROCESS_NOISE;
		cfg_data <= q;
		@(posedge clk);
		cfg_idx  <= kfr_pkg::REG_MEASUREMENT_NOISE;
		cfg_data <= r;
		@(posedge clk);
		cfg_idx  <= kfr_pkg::REG_INITIAL_ERROR;
		cfg_data <= p0;
		@(posedge clk);
		cfg_idx  <= REG_SPARE;
		cfg_data <= kfr_pkg::reg_t'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		noise_q  = q;
		noise_r  = r;
		err_init = p0;
		settings_loaded++;
	endtask

	function automatic kfr_pkg::reg_t pick_reg(input kfr_pkg::reg_t lo);
		case ($urandom_range(0, 5))
			0: begin
				return lo;
			end
			1: begin
				return kfr_pkg::P_MAX;
			end
			2, 3: begin
				return kfr_pkg::reg_t'($urandom_range(int'(lo), 131072));
			end
			4: begin
				return kfr_pkg::reg_t'($urandom_range(int'(lo), int'(kfr_pkg::P_MAX)));
			end
			default: begin
				return kfr_pkg::reg_t'($urandom_range(int'(lo), 4096));
			end
		endcase
	endfunction

	task automatic test_default_regs();
		kfr_pkg::sample_t vals[6] = '{16'sd0, SAMPLE_MAX, SAMPLE_MIN, -16'sd1, 16'sd1,
			16'sd12345};
		foreach (vals[i]) begin
			send_item(kfr_pkg::OP_SAMPLE, vals[i], 1'(i));
		end
	endtask

	task automatic test_restart();
		send_item(kfr_pkg::OP_RESTART, SAMPLE_MIN, 1'b1);
		send_item(kfr_pkg::OP_SAMPLE, 16'sd20000, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, -16'sd300, 1'b1);
		send_item(kfr_pkg::OP_RESTART, SAMPLE_MAX, 1'b0);
		send_item(kfr_pkg::OP_RESTART, 16'sd0, 1'b1);
		send_item(kfr_pkg::OP_SAMPLE, 16'sd100, 1'b1);
	endtask

	task automatic test_register_extremes();
		load_regs(kfr_pkg::P_MAX, 24'd1, kfr_pkg::P_MAX);
		send_item(kfr_pkg::OP_RESTART, 16'sd0, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, SAMPLE_MAX, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, SAMPLE_MIN, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, SAMPLE_MAX, 1'b1);
		load_regs('0, kfr_pkg::P_MAX, '0);
		send_item(kfr_pkg::OP_RESTART, 16'sd0, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, SAMPLE_MIN, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, SAMPLE_MAX, 1'b1);
	endtask

	// p and r both zero: the gain stays at zero
	task automatic test_zero_denominator();
		load_regs(kfr_pkg::P_MAX, '0, '0);
		send_item(kfr_pkg::OP_RESTART, 16'sd0, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, 16'sd20000, 1'b0);
		send_item(kfr_pkg::OP_SAMPLE, -16'sd20000, 1'b1);
	endtask

	// r zero pins the estimate to the sample, then a huge r drives the residual to saturation
	task automatic test_zero_noise_saturation();
		kfr_pkg::sample_t ends[2] = '{SAMPLE_MIN, SAMPLE_MAX};
		foreach (ends[i]) begin
			load_regs(kfr_pkg::RST_PROCESS_NOISE, '0, kfr_pkg::RST_INITIAL_ERROR);
			send_item(kfr_pkg::OP_RESTART, 16'sd0, 1'b0);
			send_item(kfr_pkg::OP_SAMPLE, ends[i], 1'b0);
			load_regs(kfr_pkg::RST_PROCESS_NOISE, kfr_pkg::P_MAX, kfr_pkg::RST_INITIAL_ERROR);
			send_item(kfr_pkg::OP_SAMPLE, ends[1 - i], 1'b1);
		end
	endtask

	task automatic test_backpressure();
		load_regs(kfr_pkg::RST_PROCESS_NOISE, kfr_pkg::RST_MEASUREMENT_NOISE,
			kfr_pkg::RST_INITIAL_ERROR);
		send_item(kfr_pkg::OP_RESTART, 16'sd0, 1'b0);
		rx_stall = LONG_STALL;
		tx_steady = 1'b1;
		repeat (40) begin
			send_item(kfr_pkg::OP_SAMPLE, kfr_pkg::sample_t'($urandom),
				1'($urandom_range(0, 1)));
		end
		tx_steady = 1'b0;
	endtask

	task automatic test_random_phases();
		int               target;
		int               phase_end;
		int               frame_len;
		int               mode;
		int               level;
		int               slope;
		logic             fl;
		kfr_pkg::sample_t s;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			load_regs(pick_reg('0), pick_reg(24'd1), pick_reg('0));
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			send_item(kfr_pkg::OP_RESTART, kfr_pkg::sample_t'($urandom),
				1'($urandom_range(0, 1)));
			phase_end = items_sent + $urandom_range(60, 140);
			while (items_sent < phase_end) begin
				frame_len = $urandom_range(1, 24);
				mode = $urandom_range(0, 3);
				level = $urandom_range(0, 65535) - 32768;
				slope = $urandom_range(0, 4000) - 2000;
				for (int i = 0; i < frame_len; i++) begin
					case (mode)
						0: begin
							s = kfr_pkg::sample_t'($urandom);
						end
						1: begin
							s = kfr_pkg::sample_t'(int'($urandom_range(0, 512)) - 256);
						end
						2: begin
							level = level + slope;
							if (level > 32767 || level < -32768) begin
								slope = -slope;
								level = level + 2 * slope;
							end
							s = kfr_pkg::sample_t'(level);
						end
						default: begin
							s = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
						end
					endcase
					// break the frame now and then
					if ($urandom_range(0, 39) == 0) begin
						send_item(kfr_pkg::OP_RESTART, kfr_pkg::sample_t'($urandom),
							1'($urandom_range(0, 1)));
					end
					fl = (i == frame_len - 1) ^ ($urandom_range(0, 29) == 0);
					send_item(kfr_pkg::OP_SAMPLE, s, fl);
				end
				if ($urandom_range(0, 7) == 0) begin
					send_item(kfr_pkg::OP_RESTART, kfr_pkg::sample_t'($urandom),
						1'($urandom_range(0, 1)));
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_idx              = kfr_pkg::REG_PROCESS_NOISE;
		cfg_data             = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.op         = kfr_pkg::OP_SAMPLE;
		sample_ch.sample     = '0;
		sample_ch.frame_last = 1'b0;
		noise_q              = kfr_pkg::RST_PROCESS_NOISE;
		noise_r              = kfr_pkg::RST_MEASUREMENT_NOISE;
		err_init             = kfr_pkg::RST_INITIAL_ERROR;
		err_p                = kfr_pkg::RST_INITIAL_ERROR;
		track_est            = '0;
		tx_steady            = 1'b0;
		rx_steady            = 1'b0;
		rx_stall             = 0;
		mismatches           = 0;
		items_sent           = 0;
		restarts_sent        = 0;
		residuals_checked    = 0;
		settings_loaded      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_regs();
		test_restart();
		test_register_extremes();
		test_zero_denominator();
		test_zero_noise_saturation();
		test_backpressure();
		test_random_phases();
		drain();
		$display("Sent %0d input items (%0d restarts) over %0d register settings.",
			items_sent, restarts_sent, settings_loaded);
		$display("Compared %0d residuals; %0d mismatches.", residuals_checked, mismatches);
		if (mismatches == 0) begin
			$display("scalar_kalman_residual_filter_top test passed");
		end else begin
			$display("scalar_kalman_residual_filter_top test failed");
		end
		$finish;
	end

endmodule
